/* rtl/core/ohlc_bar_aggregator_assert.svh */
// Assertion macros shared by the OHLC bar aggregator RTL.
`ifndef OHLC_BAR_AGGREGATOR_ASSERT_SVH
`define OHLC_BAR_AGGREGATOR_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define OHLC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("ohlc assertion failed");

// Check that an antecedent implies a consequent in the same cycle.
`define OHLC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ohlc implication failed");

`endif

/* rtl/core/ohlc_pkg.sv */
// Shared widths, constants and types for the OHLC bar aggregator.
package ohlc_pkg;

  localparam int unsigned TIME_W  = 17;
  localparam int unsigned PRICE_W = 32;
  localparam int unsigned VOL_W   = 40;
  localparam int unsigned BVOL_W  = VOL_W + 1;

  localparam int unsigned MINUTE_SECONDS  = 60;
  localparam int unsigned BAR_SECONDS_DEF = 60 * 15;

  // Reciprocal scaling for division of a time value by a constant.
  localparam int unsigned RECIP_SHIFT = TIME_W + 12;
  localparam int unsigned MIN_RECIP   = (2 ** RECIP_SHIFT) / MINUTE_SECONDS;
  localparam int unsigned MIN_RECIP_W = $clog2(MIN_RECIP + 1);
  localparam int unsigned MIN_QUO_W   = $clog2((2 ** TIME_W) / MINUTE_SECONDS + 1);

  typedef struct packed {
    logic [TIME_W-1:0]  tick_time;
    logic [TIME_W-1:0]  minute_floor;
    logic [PRICE_W-1:0] tick_price;
    logic [VOL_W-1:0]   cum_volume;
  } tick_stage_t;

endpackage

/* rtl/core/ohlc_if.sv */
// Valid/ready stream interfaces for ticks in and finished bars out.
interface ohlc_tick_if import ohlc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TIME_W-1:0]  tick_time;
  logic [PRICE_W-1:0] tick_price;
  logic [VOL_W-1:0]   cum_volume;

  modport source (output valid, output tick_time, output tick_price, output cum_volume,
                  input ready);
  modport sink   (input valid, input tick_time, input tick_price, input cum_volume,
                  output ready);
endinterface

interface ohlc_bar_if import ohlc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [TIME_W-1:0]        bar_start;
  logic [TIME_W-1:0]        bar_end;
  logic [PRICE_W-1:0]       open_price;
  logic [PRICE_W-1:0]       high_price;
  logic [PRICE_W-1:0]       low_price;
  logic [PRICE_W-1:0]       close_price;
  logic signed [BVOL_W-1:0] bar_volume;

  modport source (output valid, output bar_start, output bar_end, output open_price,
                  output high_price, output low_price, output close_price,
                  output bar_volume, input ready);
  modport sink   (input valid, input bar_start, input bar_end, input open_price,
                  input high_price, input low_price, input close_price,
                  input bar_volume, output ready);
endinterface

/* rtl/core/ohlc_bar_aggregator.sv */
// OHLC bar aggregator: turns a time-ordered tick stream into finished bars.
//
// Ticks arrive on tick_i (valid/ready, one word per tick: second of day,
// price in 1/10000 units, cumulative volume). Finished bars leave on bar_o.
// cfg_we_i/cfg_wdata_i write the resume time; ticks before it are dropped.
// Write it only while no tick is in flight.
// A tick is taken into an input register, then updated against the bar
// state; a tick that closes a bar loads the output register.
// A closing tick passes the input register and then the output register before its bar appears on bar_o.
// One tick per cycle is taken when bar_o is not stalled; the limit is the
// single state update per cycle, which holds the reciprocal multiply for the
// window advance.
// When bar_o stalls with a bar held, the input register still drains ticks
// that do not close a bar; a second closing tick waits there and tick_i
// drops ready.
// Reset clears the window state and the resume time; the open bar at the
// end of the stream is never sent.
`include "ohlc_bar_aggregator_assert.svh"

module ohlc_bar_aggregator import ohlc_pkg::*; #(
  parameter int unsigned BAR_SECONDS = BAR_SECONDS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [TIME_W-1:0] cfg_wdata_i,
  ohlc_tick_if.sink         tick_i,
  ohlc_bar_if.source        bar_o
);

  localparam int unsigned BAR_RECIP   = (2 ** RECIP_SHIFT) / BAR_SECONDS;
  localparam int unsigned BAR_RECIP_W = $clog2(BAR_RECIP + 1);
  localparam int unsigned BAR_QUO_W   = $clog2((2 ** TIME_W) / BAR_SECONDS + 1);
  localparam int unsigned BAR_PROD_W  = TIME_W + BAR_RECIP_W;
  localparam int unsigned MIN_PROD_W  = TIME_W + MIN_RECIP_W;
  localparam logic [TIME_W-1:0] BAR_C = TIME_W'(BAR_SECONDS);
  localparam logic [TIME_W-1:0] MIN_C = TIME_W'(MINUTE_SECONDS);

  // Configuration
  logic [TIME_W-1:0] resume_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      resume_q <= '0;
    end else if (cfg_we_i) begin
      resume_q <= cfg_wdata_i;
    end
  end

  // Minute floor of the incoming tick, taken before the input register
  logic [MIN_PROD_W-1:0] min_prod;
  logic [MIN_QUO_W-1:0]  min_quo;
  logic [TIME_W-1:0]     min_rem;
  logic [TIME_W-1:0]     min_rem_fix;

  assign min_prod    = MIN_PROD_W'(tick_i.tick_time) * MIN_PROD_W'(MIN_RECIP);
  assign min_quo     = min_prod[RECIP_SHIFT +: MIN_QUO_W];
  assign min_rem     = tick_i.tick_time - TIME_W'(TIME_W'(min_quo) * MIN_C);
  assign min_rem_fix = (min_rem >= MIN_C) ? (min_rem - MIN_C) : min_rem;

  // Input register
  tick_stage_t s1_q;
  logic        s1_valid_q;
  logic        s1_adv;
  logic        tick_acc;

  assign tick_i.ready = !s1_valid_q || s1_adv;
  assign tick_acc     = tick_i.valid && tick_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (tick_i.ready) begin
      s1_valid_q <= tick_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_acc) begin
      s1_q.tick_time    <= tick_i.tick_time;
      s1_q.minute_floor <= tick_i.tick_time - min_rem_fix;
      s1_q.tick_price   <= tick_i.tick_price;
      s1_q.cum_volume   <= tick_i.cum_volume;
    end
  end

  // Bar state
  logic               win_open_q;
  logic [TIME_W-1:0]  win_start_q, win_start_d;
  logic [PRICE_W-1:0] first_q, max_q, min_q, last_q;
  logic [VOL_W-1:0]   first_vol_q, last_vol_q;

  logic              keep, before_win, late, emit;
  logic [TIME_W-1:0] diff;
  logic [BAR_PROD_W-1:0] bar_prod;
  logic [BAR_QUO_W-1:0]  bar_quo;
  logic [TIME_W-1:0]     bar_rem, bar_rem_fix;

  assign keep       = s1_q.tick_time >= resume_q;
  assign before_win = s1_q.tick_time < win_start_q;
  assign diff       = s1_q.tick_time - win_start_q;
  assign late       = diff >= BAR_C;
  assign emit       = s1_valid_q && keep && win_open_q && !before_win && late;

  // Advance the window by whole bar lengths: new start = tick - (diff mod bar)
  assign bar_prod    = BAR_PROD_W'(diff) * BAR_PROD_W'(BAR_RECIP);
  assign bar_quo     = bar_prod[RECIP_SHIFT +: BAR_QUO_W];
  assign bar_rem     = diff - TIME_W'(TIME_W'(bar_quo) * BAR_C);
  assign bar_rem_fix = (bar_rem >= BAR_C) ? (bar_rem - BAR_C) : bar_rem;
  assign win_start_d = win_open_q ? (s1_q.tick_time - bar_rem_fix) : s1_q.minute_floor;

  // Output register
  logic bar_valid_q;
  logic out_free;

  assign out_free = !bar_valid_q || bar_o.ready;
  assign s1_adv   = s1_valid_q && (!emit || out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_open_q  <= 1'b0;
      win_start_q <= '0;
      first_q     <= '0;
      max_q       <= '0;
      min_q       <= '0;
      last_q      <= '0;
      first_vol_q <= '0;
      last_vol_q  <= '0;
    end else if (s1_adv && keep && !(win_open_q && before_win)) begin
      if (!win_open_q || late) begin
        // open a new bar with this tick
        win_open_q  <= 1'b1;
        win_start_q <= win_start_d;
        first_q     <= s1_q.tick_price;
        max_q       <= s1_q.tick_price;
        min_q       <= s1_q.tick_price;
        last_q      <= s1_q.tick_price;
        first_vol_q <= s1_q.cum_volume;
        last_vol_q  <= s1_q.cum_volume;
      end else begin
        if (s1_q.tick_price > max_q) begin
          max_q <= s1_q.tick_price;
        end
        if (s1_q.tick_price < min_q) begin
          min_q <= s1_q.tick_price;
        end
        last_q     <= s1_q.tick_price;
        last_vol_q <= s1_q.cum_volume;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bar_valid_q <= 1'b0;
    end else if (s1_adv && emit) begin
      bar_valid_q <= 1'b1;
    end else if (bar_o.ready) begin
      bar_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && emit) begin
      bar_o.bar_start   <= win_start_q;
      bar_o.bar_end     <= TIME_W'(win_start_q + BAR_C);
      bar_o.open_price  <= first_q;
      bar_o.high_price  <= max_q;
      bar_o.low_price   <= min_q;
      bar_o.close_price <= last_q;
      bar_o.bar_volume  <= $signed({1'b0, last_vol_q}) - $signed({1'b0, first_vol_q});
    end
  end

  assign bar_o.valid = bar_valid_q;

  // Assertions
  `OHLC_ASSERT_IMP(a_last_in_range, win_open_q, (min_q <= last_q) && (last_q <= max_q))
  `OHLC_ASSERT_IMP(a_first_in_range, win_open_q, (min_q <= first_q) && (first_q <= max_q))
  `OHLC_ASSERT_IMP(a_rem_below_bar, emit, bar_rem_fix < BAR_C)
  `OHLC_ASSERT_IMP(a_bar_from_stage, $rose(bar_valid_q), $past(s1_valid_q))
  `OHLC_ASSERT_IMP(a_empty_stage_ready, !s1_valid_q, tick_i.ready)

endmodule
